FILE: design/xcr_pkg.sv
// shared types, codes and constants for the xmodem checksum receiver
// no dependencies
`timescale 1ns / 1ps

package xcr_pkg;

    localparam int PAYLOAD_BYTES        = 128;
    localparam int WORDS_PER_PACKET     = PAYLOAD_BYTES / 4;
    localparam int WORD_IDX_W           = $clog2(WORDS_PER_PACKET);
    localparam int PACKETS_PER_PAGE_DEF = 4;
    localparam int FRAME_LAST           = PAYLOAD_BYTES + 3;

    localparam int RETRIES_W  = 8;
    localparam int END_PAGE_W = 14;
    localparam int PAGE_W     = 13;
    localparam int DONE_W     = 16;
    localparam int SIZE_W     = 23;
    localparam int CFG_DATA_W = 14;

    localparam logic [RETRIES_W-1:0]  RETRIES_RESET  = 8'd30;
    localparam logic [END_PAGE_W-1:0] END_PAGE_RESET = 14'd4096;

    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] EOT_BYTE = 8'h04;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic CFG_TIMEOUT_RETRIES = 1'b0;
    localparam logic CFG_END_PAGE        = 1'b1;

    typedef enum logic [2:0] {
        KIND_NAK    = 3'd0,
        KIND_ACK    = 3'd1,
        KIND_DATA   = 3'd2,
        KIND_COMMIT = 3'd3,
        KIND_DONE   = 3'd4,
        KIND_ABORT  = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_NAK_LAST,
        S_ABORT,
        S_EOT_ACK,
        S_EOT_COMMIT,
        S_DONE,
        S_ACK,
        S_READ,
        S_DATA,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic  latch_in;
        logic  start;
        logic  tick;
        logic  abort;
        logic  stop;
        logic  byte_step;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
        logic  rd_word;
        logic  word_clr;
        logic  word_inc;
        logic  adv_packet;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       active;
        logic       eot_start;
        logic       frame_end;
        logic       is_soh;
        logic       frame_ok;
        logic       retry_ok;
        logic       block_match;
        logic       slot_nonzero;
        logic       slot_last;
        logic       word_last;
        logic       out_free;
    } dp_stat_t;

endpackage

FILE: design/xcr_dp.sv
// datapath: config registers, frame state, payload memory, page tracking, result register
// depends on xcr_pkg
`timescale 1ns / 1ps

module xcr_dp
    import xcr_pkg::*;
#(
    parameter int PACKETS_PER_PAGE = PACKETS_PER_PAGE_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]             command,
    input  logic [7:0]             rx_byte,
    input  logic                   out_ready,
    input  dp_cmd_t                ctl,
    output dp_stat_t               stat,
    output logic                   out_valid,
    output logic [2:0]             kind,
    output logic [31:0]            data_word,
    output logic [6:0]             word_index,
    output logic [PAGE_W-1:0]      flash_page,
    output logic [SIZE_W-1:0]      image_size,
    output logic                   last
);

    localparam int SLOT_W    = (PACKETS_PER_PAGE > 1) ? $clog2(PACKETS_PER_PAGE) : 1;
    localparam int MEM_WORDS = WORDS_PER_PACKET;

    logic [RETRIES_W-1:0]  retries_reg;
    logic [END_PAGE_W-1:0] end_page_reg;

    logic [1:0]            in_cmd_reg;
    logic [7:0]            in_byte_reg;

    logic                  active_reg, active_next;
    logic [7:0]            fp_reg, fp_next;
    logic [DONE_W-1:0]     done_reg, done_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [PAGE_W-1:0]     quot_reg, quot_next;
    logic [7:0]            bn_reg, bn_next;
    logic [7:0]            bc_reg, bc_next;
    logic [7:0]            sum_reg, sum_next;
    logic [7:0]            ftype_reg, ftype_next;
    logic [RETRIES_W-1:0]  tcount_reg, tcount_next;
    logic [WORD_IDX_W-1:0] w_reg, w_next;

    logic [31:0]           buf_mem [MEM_WORDS];
    logic [31:0]           rd_data_reg;
    logic                  mem_we;
    logic [6:0]            wr_pos;

    logic                  out_valid_reg;
    kind_t                 kind_reg;
    logic [31:0]           data_reg;
    logic [6:0]            widx_reg;
    logic [PAGE_W-1:0]     page_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic                  last_reg;

    logic [PAGE_W-1:0]     cur_page;
    logic                  slot_last;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retries_reg  <= RETRIES_RESET;
            end_page_reg <= END_PAGE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT_RETRIES: retries_reg  <= cfg_data[RETRIES_W-1:0];
                CFG_END_PAGE:        end_page_reg <= cfg_data[END_PAGE_W-1:0];
                default:             retries_reg  <= retries_reg;
            endcase
        end
    end

    // input beat capture
    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            in_cmd_reg  <= command;
            in_byte_reg <= rx_byte;
        end
    end

    assign slot_last = (slot_reg == SLOT_W'(PACKETS_PER_PAGE - 1));
    assign cur_page  = end_page_reg[PAGE_W-1:0] - PAGE_W'(1) - quot_reg;
    assign wr_pos    = 7'(fp_reg - 8'd3);
    assign mem_we    = ctl.byte_step && (fp_reg > 8'd2) && (fp_reg < 8'(FRAME_LAST));

    always_comb
    begin
        active_next = active_reg;
        fp_next     = fp_reg;
        done_next   = done_reg;
        slot_next   = slot_reg;
        quot_next   = quot_reg;
        bn_next     = bn_reg;
        bc_next     = bc_reg;
        sum_next    = sum_reg;
        ftype_next  = ftype_reg;
        tcount_next = tcount_reg;
        w_next      = w_reg;

        if (ctl.start)
        begin
            active_next = 1'b1;
            fp_next     = '0;
            done_next   = '0;
            slot_next   = '0;
            quot_next   = '0;
            sum_next    = '0;
            tcount_next = '0;
        end
        if (ctl.tick)
            tcount_next = tcount_reg + RETRIES_W'(1);
        if (ctl.abort)
        begin
            active_next = 1'b0;
            fp_next     = '0;
        end
        if (ctl.stop)
            active_next = 1'b0;
        if (ctl.byte_step)
        begin
            if (fp_reg == 8'd0)
            begin
                ftype_next = in_byte_reg;
                sum_next   = '0;
                fp_next    = 8'd1;
            end
            else if (fp_reg == 8'd1)
            begin
                bn_next = in_byte_reg;
                fp_next = 8'd2;
            end
            else if (fp_reg == 8'd2)
            begin
                bc_next = in_byte_reg;
                fp_next = 8'd3;
            end
            else if (fp_reg < 8'(FRAME_LAST))
            begin
                sum_next = sum_reg + in_byte_reg;
                fp_next  = fp_reg + 8'd1;
            end
            else
            begin
                fp_next = '0;
            end
        end
        if (ctl.word_clr)
            w_next = '0;
        if (ctl.word_inc)
            w_next = w_reg + WORD_IDX_W'(1);
        if (ctl.adv_packet)
        begin
            if (done_reg == {DONE_W{1'b1}})
            begin
                done_next = '0;
                slot_next = '0;
                quot_next = '0;
            end
            else
            begin
                done_next = done_reg + DONE_W'(1);
                if (slot_last)
                begin
                    slot_next = '0;
                    quot_next = quot_reg + PAGE_W'(1);
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            fp_reg     <= '0;
            done_reg   <= '0;
            slot_reg   <= '0;
            quot_reg   <= '0;
            bn_reg     <= '0;
            bc_reg     <= '0;
            sum_reg    <= '0;
            ftype_reg  <= '0;
            tcount_reg <= '0;
            w_reg      <= '0;
        end
        else
        begin
            active_reg <= active_next;
            fp_reg     <= fp_next;
            done_reg   <= done_next;
            slot_reg   <= slot_next;
            quot_reg   <= quot_next;
            bn_reg     <= bn_next;
            bc_reg     <= bc_next;
            sum_reg    <= sum_next;
            ftype_reg  <= ftype_next;
            tcount_reg <= tcount_next;
            w_reg      <= w_next;
        end
    end

    // payload memory, byte-lane writes, word reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
            buf_mem[wr_pos[6:2]][wr_pos[1:0]*8 +: 8] <= in_byte_reg;
        if (ctl.rd_word)
            rd_data_reg <= buf_mem[w_reg];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            kind_reg <= ctl.emit_kind;
            last_reg <= ctl.emit_last;
            data_reg <= (ctl.emit_kind == KIND_DATA) ? rd_data_reg : 32'd0;
            widx_reg <= (ctl.emit_kind == KIND_DATA)
                        ? 7'(7'(slot_reg) * 7'(WORDS_PER_PACKET)) + 7'(w_reg) : 7'd0;
            page_reg <= (ctl.emit_kind == KIND_DATA || ctl.emit_kind == KIND_COMMIT)
                        ? cur_page : '0;
            size_reg <= (ctl.emit_kind == KIND_DONE) ? SIZE_W'({done_reg, 7'd0}) : '0;
        end
    end

    assign stat.cmd          = in_cmd_reg;
    assign stat.active       = active_reg;
    assign stat.eot_start    = (fp_reg == 8'd0) && (in_byte_reg == EOT_BYTE);
    assign stat.frame_end    = (fp_reg >= 8'(FRAME_LAST));
    assign stat.is_soh       = (ftype_reg == SOH_BYTE);
    assign stat.frame_ok     = (({1'b0, bn_reg} + {1'b0, bc_reg}) == 9'h0FF)
                               && (sum_reg == in_byte_reg);
    assign stat.retry_ok     = (tcount_reg < retries_reg);
    assign stat.block_match  = (bn_reg == 8'(done_reg[7:0] + 8'd1));
    assign stat.slot_nonzero = (slot_reg != '0);
    assign stat.slot_last    = slot_last;
    assign stat.word_last    = (w_reg == WORD_IDX_W'(WORDS_PER_PACKET - 1));
    assign stat.out_free     = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign data_word  = data_reg;
    assign word_index = widx_reg;
    assign flash_page = page_reg;
    assign image_size = size_reg;
    assign last       = last_reg;

endmodule

FILE: design/xcr_ctrl.sv
// controller state machine: decodes each input beat and sequences the result beats
// depends on xcr_pkg
`timescale 1ns / 1ps

module xcr_ctrl
    import xcr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.emit_kind = KIND_NAK;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_IDLE;
                unique case (stat.cmd)
                    CMD_START:
                    begin
                        ctl.start  = 1'b1;
                        state_next = S_NAK_LAST;
                    end
                    CMD_TIMEOUT:
                    begin
                        if (stat.active)
                        begin
                            if (stat.retry_ok)
                            begin
                                ctl.tick   = 1'b1;
                                state_next = S_NAK_LAST;
                            end
                            else
                            begin
                                ctl.abort  = 1'b1;
                                state_next = S_ABORT;
                            end
                        end
                    end
                    CMD_BYTE:
                    begin
                        if (stat.active)
                        begin
                            if (stat.eot_start)
                            begin
                                ctl.stop   = 1'b1;
                                state_next = S_EOT_ACK;
                            end
                            else
                            begin
                                ctl.byte_step = 1'b1;
                                if (stat.frame_end && stat.is_soh)
                                begin
                                    if (stat.frame_ok)
                                    begin
                                        ctl.word_clr = 1'b1;
                                        state_next   = S_ACK;
                                    end
                                    else
                                    begin
                                        state_next = S_NAK_LAST;
                                    end
                                end
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_NAK_LAST:
            begin
                if (stat.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_NAK;
                    ctl.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_ABORT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_ABORT;
                    ctl.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_EOT_ACK:
            begin
                if (stat.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_ACK;
                    state_next    = stat.slot_nonzero ? S_EOT_COMMIT : S_DONE;
                end
            end

            S_EOT_COMMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_COMMIT;
                    state_next    = S_DONE;
                end
            end

            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_DONE;
                    ctl.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_ACK:
            begin
                if (stat.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_ACK;
                    ctl.emit_last = !stat.block_match;
                    state_next    = stat.block_match ? S_READ : S_IDLE;
                end
            end

            S_READ:
            begin
                ctl.rd_word = 1'b1;
                state_next  = S_DATA;
            end

            S_DATA:
            begin
                if (stat.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_DATA;
                    ctl.emit_last = stat.word_last && !stat.slot_last;
                    if (!stat.word_last)
                    begin
                        ctl.word_inc = 1'b1;
                        state_next   = S_READ;
                    end
                    else if (stat.slot_last)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        ctl.adv_packet = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end

            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit       = 1'b1;
                    ctl.emit_kind  = KIND_COMMIT;
                    ctl.emit_last  = 1'b1;
                    ctl.adv_packet = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/xmodem_checksum_receiver_top.sv
// Receives an XMODEM download with the 8-bit checksum, one beat per command or byte, and
// answers with NAK/ACK, payload words placed in flash pages filling down from end_page,
// page commits, the final image size or an abort. Each command or byte beat is captured,
// then decoded, and its result beats are issued before the next beat is taken. A good
// frame carrying the expected block holds the input for 32 data words read one at a time
// from the payload memory, each word read and then emitted, with a page commit after the
// last packet of a page and any output stall in between; each result waits in one
// output register and may be taken while the next decode proceeds.
// depends on xcr_pkg, xcr_ctrl, xcr_dp
`timescale 1ns / 1ps

module xmodem_checksum_receiver_top
    import xcr_pkg::*;
#(
    parameter int PACKETS_PER_PAGE = PACKETS_PER_PAGE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            kind,
    output logic [31:0]           data_word,
    output logic [6:0]            word_index,
    output logic [PAGE_W-1:0]     flash_page,
    output logic [SIZE_W-1:0]     image_size,
    output logic                  last
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    xcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    xcr_dp #(
        .PACKETS_PER_PAGE (PACKETS_PER_PAGE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .command    (command),
        .rx_byte    (rx_byte),
        .out_ready  (out_ready),
        .ctl        (ctl),
        .stat       (stat),
        .out_valid  (out_valid),
        .kind       (kind),
        .data_word  (data_word),
        .word_index (word_index),
        .flash_page (flash_page),
        .image_size (image_size),
        .last       (last)
    );

endmodule

FILE: sim/xmodem_checksum_receiver_top_tb.sv
// testbench for xmodem_checksum_receiver_top: drives downloads of checksum frames,
// predicts every NAK/ACK, data word, commit, done and abort beat and checks them in order
// depends on xcr_pkg and the receiver rtl
`timescale 1ns / 1ps

module xmodem_checksum_receiver_top_tb;
    import xcr_pkg::*;

    localparam int PKT_PER_PAGE  = PACKETS_PER_PAGE_DEF;
    localparam int FRAME_BYTES   = PAYLOAD_BYTES + 4;
    localparam int HOLD_CYCLES   = 1500;
    localparam int TIMEOUT_NS    = 12_000_000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int END_EOT   = 0;
    localparam int END_ABORT = 1;
    localparam int END_OPEN  = 2;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] word;
        logic [6:0]  idx;
        logic [12:0] page;
        logic [22:0] img_size;
        logic        last;
    } rx_result_t;

    class download_scoreboard;
        rx_result_t  due_results[$];
        logic [7:0]  retries;
        logic [13:0] end_page;
        bit          active;
        int          pos;
        logic [15:0] next_pkt;
        logic [7:0]  blk;
        logic [7:0]  blk_inv;
        logic [7:0]  csum;
        logic [7:0]  ftype;
        logic [7:0]  tmo_cnt;
        logic [7:0]  payload [PAYLOAD_BYTES];
        int          errors;
        int          n_results;
        int          n_words;
        int          n_commits;
        int          n_aborts;

        function new();
            retries   = RETRIES_RESET;
            end_page  = END_PAGE_RESET;
            active    = 1'b0;
            pos       = 0;
            next_pkt  = 16'd1;
            blk       = 8'd0;
            blk_inv   = 8'd0;
            csum      = 8'd0;
            ftype     = 8'd0;
            tmo_cnt   = 8'd0;
            errors    = 0;
            n_results = 0;
            n_words   = 0;
            n_commits = 0;
            n_aborts  = 0;
            foreach (payload[i])
                payload[i] = 8'd0;
        endfunction

        function void set_reg(logic idx, logic [13:0] val);
            if (idx == CFG_TIMEOUT_RETRIES)
                retries = val[7:0];
            else
                end_page = val;
        endfunction

        function void add(kind_t k, logic [31:0] w, logic [6:0] ix, logic [12:0] pg,
                          logic [22:0] sz);
            rx_result_t r;
            r.kind     = k;
            r.word     = w;
            r.idx      = ix;
            r.page     = pg;
            r.img_size = sz;
            r.last     = 1'b0;
            due_results.push_back(r);
        endfunction

        function logic [12:0] page_of_done(logic [15:0] done);
            logic [31:0] p;
            p = {18'd0, end_page} - 32'd1 - 32'(done / PKT_PER_PAGE);
            return p[12:0];
        endfunction

        function void take_beat(logic [1:0] cmd, logic [7:0] b);
            int          n_prior;
            int          slot;
            logic [15:0] done;
            logic [12:0] pg;
            logic [31:0] w32;
            rx_result_t  r;
            n_prior = due_results.size();
            if (cmd == CMD_START)
            begin
                active   = 1'b1;
                pos      = 0;
                next_pkt = 16'd1;
                csum     = 8'd0;
                tmo_cnt  = 8'd0;
                add(KIND_NAK, 0, 0, 0, 0);
            end
            else if (cmd == CMD_TIMEOUT && active)
            begin
                if (tmo_cnt < retries)
                begin
                    tmo_cnt = tmo_cnt + 8'd1;
                    add(KIND_NAK, 0, 0, 0, 0);
                end
                else
                begin
                    active = 1'b0;
                    pos    = 0;
                    add(KIND_ABORT, 0, 0, 0, 0);
                end
            end
            else if (cmd == CMD_BYTE && active)
            begin
                if (pos == 0 && b == EOT_BYTE)
                begin
                    done = next_pkt - 16'd1;
                    add(KIND_ACK, 0, 0, 0, 0);
                    if (done % PKT_PER_PAGE != 0)
                        add(KIND_COMMIT, 0, 0, page_of_done(done), 0);
                    w32 = {16'd0, done} << 7;
                    add(KIND_DONE, 0, 0, 0, w32[22:0]);
                    active = 1'b0;
                end
                else if (pos == 0)
                begin
                    ftype = b;
                    csum  = 8'd0;
                    pos   = 1;
                end
                else if (pos == 1)
                begin
                    blk = b;
                    pos = 2;
                end
                else if (pos == 2)
                begin
                    blk_inv = b;
                    pos     = 3;
                end
                else if (pos < FRAME_LAST)
                begin
                    payload[pos - 3] = b;
                    csum = csum + b;
                    pos++;
                end
                else
                begin
                    pos = 0;
                    if (ftype == SOH_BYTE)
                    begin
                        if (({1'b0, blk} + {1'b0, blk_inv}) != 9'h0FF || csum != b)
                            add(KIND_NAK, 0, 0, 0, 0);
                        else
                        begin
                            add(KIND_ACK, 0, 0, 0, 0);
                            if (blk == next_pkt[7:0])
                            begin
                                done = next_pkt - 16'd1;
                                slot = done % PKT_PER_PAGE;
                                pg   = page_of_done(done);
                                for (int w = 0; w < WORDS_PER_PACKET; w++)
                                begin
                                    w32 = {payload[4*w+3], payload[4*w+2],
                                           payload[4*w+1], payload[4*w]};
                                    add(KIND_DATA, w32, 7'(slot * WORDS_PER_PACKET + w), pg, 0);
                                end
                                if (slot == PKT_PER_PAGE - 1)
                                    add(KIND_COMMIT, 0, 0, pg, 0);
                                next_pkt = next_pkt + 16'd1;
                            end
                        end
                    end
                end
            end
            if (due_results.size() > n_prior)
            begin
                r = due_results.pop_back();
                r.last = 1'b1;
                due_results.push_back(r);
            end
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [2:0] k, logic [31:0] w, logic [6:0] ix,
                                   logic [12:0] pg, logic [22:0] sz, logic lst);
            rx_result_t exp_r;
            if (due_results.size() == 0)
            begin
                $error("kind: expected no beat, got %0d", k);
                errors++;
                return;
            end
            exp_r = due_results.pop_front();
            n_results++;
            if (exp_r.kind == KIND_DATA)
                n_words++;
            if (exp_r.kind == KIND_COMMIT)
                n_commits++;
            if (exp_r.kind == KIND_ABORT)
                n_aborts++;
            cmp_field("kind", exp_r.kind, k);
            cmp_field("data_word", exp_r.word, w);
            cmp_field("word_index", exp_r.idx, ix);
            cmp_field("flash_page", exp_r.page, pg);
            cmp_field("image_size", exp_r.img_size, sz);
            cmp_field("last", exp_r.last, lst);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            command;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [2:0]            kind;
    logic [31:0]           data_word;
    logic [6:0]            word_index;
    logic [PAGE_W-1:0]     flash_page;
    logic [SIZE_W-1:0]     image_size;
    logic                  last;

    download_scoreboard dl_sb = new();

    bit         hold_req;
    int         holds_done;
    int         burst_left;
    int         beats_sent;
    int         tmo_used;
    int         cur_retries;
    logic [7:0] gen_block;

    xmodem_checksum_receiver_top #(
        .PACKETS_PER_PAGE(PKT_PER_PAGE)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .data_word  (data_word),
        .word_index (word_index),
        .flash_page (flash_page),
        .image_size (image_size),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            dl_sb.check_result(kind, data_word, word_index, flash_page, image_size, last);
    end

    // receiver: shifting stall patterns, plus one long hold-off on request
    initial
    begin
        int mode;
        int span;
        int tick;
        out_ready = 1'b0;
        mode = 0;
        span = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 200);
                end
                span--;
                tick++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (tick % 4 == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b);
        int gap;
        int pick;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 24);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                gap = 0;
            else if (pick < 85)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(10, 40);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        dl_sb.take_beat(cmd, b);
        beats_sent++;
    endtask

    task automatic settle(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (dl_sb.due_results.size() != 0)
            @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [13:0] val);
        settle(10);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        dl_sb.set_reg(idx, val);
        if (idx == CFG_TIMEOUT_RETRIES)
            cur_retries = val[7:0];
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] blk,
                              input logic [7:0] blk_inv, input logic [7:0] skew,
                              input int cut, input int n_tmo);
        logic [7:0] fb [FRAME_BYTES];
        logic [7:0] csum;
        int         fill;
        int         left;
        fill = $urandom_range(0, 9);
        csum = 8'd0;
        fb[0] = ftype;
        fb[1] = blk;
        fb[2] = blk_inv;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            fb[3 + i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
            csum = csum + fb[3 + i];
        end
        fb[FRAME_BYTES - 1] = csum + skew;
        left = n_tmo;
        for (int i = 0; i < cut; i++)
        begin
            if (left > 0 && $urandom_range(0, 39) == 0)
            begin
                send_beat(CMD_TIMEOUT, 8'($urandom));
                tmo_used++;
                left--;
            end
            send_beat(CMD_BYTE, fb[i]);
        end
    endtask

    task automatic run_session(input int n_frames, input int ending);
        int         pick;
        int         k;
        logic [7:0] other;
        send_beat(CMD_START, 8'($urandom));
        gen_block = 8'd1;
        tmo_used  = 0;
        for (int f = 0; f < n_frames; f++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                send_frame(SOH_BYTE, gen_block, ~gen_block, 8'd0, FRAME_BYTES, 0);
                gen_block++;
            end
            else if (pick < 68)
                send_frame(SOH_BYTE, gen_block, ~gen_block, 8'($urandom_range(1, 255)),
                           FRAME_BYTES, 0);
            else if (pick < 74)
                send_frame(SOH_BYTE, gen_block, ~gen_block ^ 8'($urandom_range(1, 255)),
                           8'd0, FRAME_BYTES, 0);
            else if (pick < 82)
            begin
                // duplicate or out-of-order block: acknowledged, not stored
                other = gen_block + 8'($urandom_range(1, 255));
                send_frame(SOH_BYTE, other, ~other, 8'd0, FRAME_BYTES, 0);
            end
            else if (pick < 88)
            begin
                other = 8'($urandom);
                if (other == SOH_BYTE || other == EOT_BYTE)
                    other = 8'h02;
                send_frame(other, 8'($urandom), 8'($urandom), 8'd0, FRAME_BYTES, 0);
            end
            else if (pick < 93)
            begin
                send_frame(SOH_BYTE, gen_block, ~gen_block, 8'd0,
                           $urandom_range(1, FRAME_BYTES - 1), 0);
                send_beat(CMD_START, 8'($urandom));
                gen_block = 8'd1;
                tmo_used  = 0;
            end
            else
            begin
                k = cur_retries - tmo_used;
                if (k > 3)
                    k = 3;
                send_frame(SOH_BYTE, gen_block, ~gen_block, 8'd0, FRAME_BYTES, k);
                gen_block++;
            end
        end
        if (ending == END_ABORT && cur_retries - tmo_used <= 40)
            repeat (cur_retries - tmo_used + 1) send_beat(CMD_TIMEOUT, 8'($urandom));
        else if (ending != END_OPEN)
            send_beat(CMD_BYTE, EOT_BYTE);
        repeat ($urandom_range(0, 3))
            send_beat(2'($urandom_range(1, 3)), 8'($urandom));
    endtask

    initial
    begin
        in_valid    = 1'b0;
        command     = CMD_START;
        rx_byte     = 8'd0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_TIMEOUT_RETRIES;
        cfg_data    = '0;
        rst_n       = 1'b0;
        hold_req    = 1'b0;
        holds_done  = 0;
        burst_left  = 0;
        beats_sent  = 0;
        tmo_used    = 0;
        cur_retries = RETRIES_RESET;
        gen_block   = 8'd1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle: everything but start is dropped
        send_beat(CMD_BYTE, 8'h00);
        send_beat(CMD_TIMEOUT, 8'h00);
        send_beat(CMD_UNUSED, 8'hFF);
        send_beat(CMD_BYTE, 8'hFF);
        // empty download, then restarts and timeouts around a partial frame
        send_beat(CMD_START, 8'hFF);
        send_beat(CMD_UNUSED, 8'h00);
        send_beat(CMD_BYTE, EOT_BYTE);
        send_beat(CMD_TIMEOUT, 8'hFF);
        send_beat(CMD_START, 8'h00);
        send_beat(CMD_START, 8'h55);
        send_beat(CMD_TIMEOUT, 8'hAA);
        send_beat(CMD_BYTE, SOH_BYTE);
        send_beat(CMD_TIMEOUT, 8'h00);
        send_beat(CMD_BYTE, 8'hFE);
        send_beat(CMD_BYTE, 8'h01);
        send_beat(CMD_START, 8'h00);
        send_beat(CMD_BYTE, 8'hFF);
        send_beat(CMD_START, 8'hFF);

        run_session(1, END_EOT);

        write_reg(CFG_TIMEOUT_RETRIES, 14'd0);
        write_reg(CFG_END_PAGE, 14'd1);
        run_session(0, END_ABORT);

        write_reg(CFG_TIMEOUT_RETRIES, 14'd255);
        write_reg(CFG_END_PAGE, 14'd8192);
        hold_req = 1'b1;
        run_session(1, END_EOT);

        write_reg(CFG_TIMEOUT_RETRIES, 14'($urandom_range(1, 6)));
        write_reg(CFG_END_PAGE, 14'($urandom_range(2, 8191)));
        run_session(0, $urandom_range(END_EOT, END_OPEN));
        run_session(0, END_ABORT);

        settle(80);
        $display("run covered %0d input beats and %0d results: %0d data words, %0d commits,",
                 beats_sent, dl_sb.n_results, dl_sb.n_words, dl_sb.n_commits);
        $display("%0d aborts, %0d long output hold-offs", dl_sb.n_aborts, holds_done);
        if (dl_sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: xmodem_checksum_receiver_top.f
design/xcr_pkg.sv
design/xcr_dp.sv
design/xcr_ctrl.sv
design/xmodem_checksum_receiver_top.sv
sim/xmodem_checksum_receiver_top_tb.sv
